>>> src/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types and constants of the frame motion detector: register map,
// configuration record, controller states and controller/datapath buses.
// ----------------------------------------------------------------------------
package fmd_pkg;

  // APB address width: five 32-bit registers at byte addresses 4*i
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Register indexes (paddr[4:2])
  typedef enum logic [2:0] {
    REG_FEEDBACK  = 3'd0,
    REG_GAIN      = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_BINARY    = 3'd3,
    REG_INVERT    = 3'd4
  } reg_index_t;

  localparam logic [15:0] FEEDBACK_RESET  = 16'd0;
  localparam logic [15:0] GAIN_RESET      = 16'd256;
  localparam logic [8:0]  THRESHOLD_RESET = 9'd0;

  // Output levels and rounding constant
  localparam logic [7:0]  LEVEL_HIGH = 8'd255;
  localparam logic [7:0]  LEVEL_LOW  = 8'd0;
  localparam logic [33:0] ROUND_HALF = 34'd32768;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  // Configuration record
  typedef struct packed {
    logic [15:0] feedback_coeff;
    logic [15:0] diff_gain;
    logic [8:0]  motion_threshold;
    logic        binary_mode;
    logic        invert_mode;
  } cfg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_BYPASS,
    ST_READ,
    ST_MULA,
    ST_MULB,
    ST_BLEND,
    ST_DIFF,
    ST_MULC,
    ST_OUT
  } state_t;

  // Shared multiplier operand selection
  typedef enum logic [1:0] {
    MUL_SAMPLE,
    MUL_OLD,
    MUL_GAIN
  } mul_sel_t;

  // Store write data selection
  typedef enum logic {
    WR_SAMPLE,
    WR_BLEND
  } wr_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mod_step;
    logic     clr_start;
    logic     clr_write;
    logic     rd_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     new_en;
    logic     diff_en;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic bypass;
    logic out_busy;
    logic clr_last;
  } status_t;

endpackage

>>> src/frame_motion_detector.sv
// ----------------------------------------------------------------------------
// frame_motion_detector
// Recursive-average frame-difference motion detector: keeps a Q8.8 running
// average per frame position and reports the scaled change of each sample (a fixed level in the bypass cases).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries req_type, sample, pixel_index.
//   A sample request yields one transfer on the output channel
//   (out_valid/out_ready) with motion_value and out_index; a clear request
//   yields none and zeroes the whole average store.
//   Configuration registers sit on the APB port at byte addresses 4*i;
//   write them while no item is in flight.
//   Timing: one item at a time. A sample request steps through the states
//   MOD, READ, MULA, MULB, BLEND, DIFF, MULC and OUT, which loads the output
//   register; the next item is taken once the controller is back in IDLE.
//   Threshold-bypass cases step through MOD, BYPASS and OUT. When
//   FRAME_ELEMENTS is below 65536 and not a power of two, the position is
//   reduced in MOD in two steps, a reciprocal multiply and then a subtract.
//   The single store port (one read or write per cycle) and the shared multiplier force this sequence.
//   A clear request, and reset, sweep the store one entry per cycle, with
//   in_ready low until the last entry has been written.
//   The output register holds its result while out_ready is low; a new item
//   is still accepted and its result waits in the datapath until the output
//   register frees up.
// ----------------------------------------------------------------------------
module frame_motion_detector #(
  parameter int unsigned FRAME_ELEMENTS = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fmd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fmd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fmd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [7:0]                      sample,
  input  logic [15:0]                     pixel_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      motion_value,
  output logic [15:0]                     out_index
);
  import fmd_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers
  fmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  fmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  // Store and arithmetic
  fmd_datapath #(
    .FRAME_ELEMENTS (FRAME_ELEMENTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .pixel_index  (pixel_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .motion_value (motion_value),
    .out_index    (out_index)
  );

endmodule

>>> src/fmd_regs.sv
// ----------------------------------------------------------------------------
// fmd_regs
// APB configuration registers of the frame motion detector.
// ----------------------------------------------------------------------------
module fmd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fmd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fmd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fmd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output fmd_pkg::cfg_t                   cfg
);
  import fmd_pkg::*;

  logic       wr_fire;
  reg_index_t index;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign index   = reg_index_t'(paddr[4:2]);

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feedback_coeff   <= FEEDBACK_RESET;
      cfg.diff_gain        <= GAIN_RESET;
      cfg.motion_threshold <= THRESHOLD_RESET;
      cfg.binary_mode      <= 1'b0;
      cfg.invert_mode      <= 1'b0;
    end else if (wr_fire) begin
      case (index)
        REG_FEEDBACK:  cfg.feedback_coeff   <= pwdata[15:0];
        REG_GAIN:      cfg.diff_gain        <= pwdata[15:0];
        REG_THRESHOLD: cfg.motion_threshold <= pwdata[8:0];
        REG_BINARY:    cfg.binary_mode      <= pwdata[0];
        REG_INVERT:    cfg.invert_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (index)
      REG_FEEDBACK:  prdata = APB_DATA_W'(cfg.feedback_coeff);
      REG_GAIN:      prdata = APB_DATA_W'(cfg.diff_gain);
      REG_THRESHOLD: prdata = APB_DATA_W'(cfg.motion_threshold);
      REG_BINARY:    prdata = APB_DATA_W'(cfg.binary_mode);
      REG_INVERT:    prdata = APB_DATA_W'(cfg.invert_mode);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> src/fmd_datapath.sv
// ----------------------------------------------------------------------------
// fmd_datapath
// Average store, slot reduction, shared multiplier, blend and decision logic,
// and the output register of the frame motion detector.
// ----------------------------------------------------------------------------
module fmd_datapath #(
  parameter int unsigned FRAME_ELEMENTS = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  fmd_pkg::cfg_t     cfg,
  input  fmd_pkg::cmd_t     cmd,
  output fmd_pkg::status_t  status,
  input  logic [7:0]        sample,
  input  logic [15:0]       pixel_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        motion_value,
  output logic [15:0]       out_index
);
  import fmd_pkg::*;

  localparam int unsigned AW = (FRAME_ELEMENTS > 1) ? $clog2(FRAME_ELEMENTS) : 1;
  localparam bit DIRECT = (FRAME_ELEMENTS >= 65536) ||
                          ((FRAME_ELEMENTS & (FRAME_ELEMENTS - 1)) == 0);
  localparam bit SINGLE = (FRAME_ELEMENTS == 1);
  localparam logic [15:0] N16    = 16'(FRAME_ELEMENTS);
  localparam logic [32:0] RECIP  = 33'(((64'd1 << 32) + 64'(FRAME_ELEMENTS) - 64'd1) /
                                       64'(FRAME_ELEMENTS));
  localparam logic [AW-1:0] LAST_A = AW'(FRAME_ELEMENTS - 1);

  // Store and item registers
  logic [15:0]    store [FRAME_ELEMENTS];
  logic [7:0]     sample_q;
  logic [15:0]    pix_q;
  logic [15:0]    old_q;
  logic [15:0]    new_q;
  logic [15:0]    diff_q;
  logic [32:0]    prod;
  logic [32:0]    acc;
  logic [AW-1:0]  clr_addr;

  // Slot reduction unit
  logic [48:0]    q_prod;
  logic [15:0]    quot;
  logic [31:0]    qn_prod;
  logic [15:0]    rem_full;
  logic [AW-1:0]  rem;
  logic           mod_phase;
  logic           mod_done_q;
  logic [AW+15:0] pix_ext;
  logic [AW-1:0]  slot;

  logic [15:0]    sample16;
  logic [15:0]    mul_a;
  logic [16:0]    mul_b;
  logic [33:0]    blend_sum;
  logic [17:0]    blend_res;
  logic [15:0]    blend_new;
  logic [16:0]    mag;
  logic           pass;
  logic [7:0]     level_high;
  logic [7:0]     level_low;
  logic [7:0]     val;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [15:0]    mem_wdata;

  assign sample16 = {sample_q, 8'd0};

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_q <= sample;
      pix_q    <= pixel_index;
    end
  end

  // Reduce the index by the store depth: reciprocal multiply for the
  // quotient, then subtract quotient times depth for the remainder
  assign q_prod   = 49'(pix_q) * 49'(RECIP);
  assign qn_prod  = 32'(quot) * 32'(N16);
  assign rem_full = pix_q - qn_prod[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_phase  <= 1'b0;
      mod_done_q <= 1'b0;
    end else if (cmd.load_in) begin
      mod_phase  <= 1'b0;
      mod_done_q <= 1'b0;
    end else if (cmd.mod_step) begin
      mod_phase  <= 1'b1;
      mod_done_q <= mod_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_step) begin
      if (!mod_phase) begin
        quot <= q_prod[47:32];
      end else begin
        rem <= AW'(rem_full);
      end
    end
  end

  assign pix_ext = {{AW{1'b0}}, pix_q};
  assign slot    = SINGLE ? '0 : (DIRECT ? pix_ext[AW-1:0] : rem);

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Store port: one write or one registered read per cycle
  assign mem_we    = cmd.clr_write || cmd.wr_en;
  assign mem_addr  = cmd.clr_write ? clr_addr : slot;
  assign mem_wdata = cmd.clr_write ? 16'd0 :
                     (cmd.wr_sel == WR_SAMPLE) ? sample16 : new_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      old_q <= store[mem_addr];
    end
  end

  // Shared multiplier, registered product
  always_comb begin
    case (cmd.mul_sel)
      MUL_SAMPLE: begin
        mul_a = sample16;
        mul_b = ONE_Q16 - {1'b0, cfg.feedback_coeff};
      end
      MUL_OLD: begin
        mul_a = old_q;
        mul_b = {1'b0, cfg.feedback_coeff};
      end
      MUL_GAIN: begin
        mul_a = diff_q;
        mul_b = {1'b0, cfg.diff_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= 33'(mul_a) * 33'(mul_b);
    end
    if (cmd.acc_en) begin
      acc <= prod;
    end
  end

  // Blend with round half up, saturate to 16 bits
  assign blend_sum = {1'b0, acc} + {1'b0, prod} + ROUND_HALF;
  assign blend_res = blend_sum[33:16];
  assign blend_new = (blend_res > 18'd65535) ? 16'hFFFF : blend_res[15:0];

  always_ff @(posedge clk) begin
    if (cmd.new_en) begin
      new_q <= blend_new;
    end
    if (cmd.diff_en) begin
      diff_q <= (new_q >= old_q) ? (new_q - old_q) : (old_q - new_q);
    end
  end

  // Decide the output level
  assign mag        = prod[32:16];
  assign pass       = (mag >= {8'd0, cfg.motion_threshold});
  assign level_high = cfg.invert_mode ? LEVEL_LOW : LEVEL_HIGH;
  assign level_low  = cfg.invert_mode ? LEVEL_HIGH : LEVEL_LOW;

  always_comb begin
    if (cfg.motion_threshold > 9'd255) begin
      val = cfg.binary_mode ? level_low : LEVEL_LOW;
    end else if (cfg.binary_mode && (cfg.motion_threshold == 9'd0)) begin
      val = level_high;
    end else if (cfg.binary_mode) begin
      val = pass ? level_high : level_low;
    end else if (pass) begin
      val = (mag > 17'd255) ? LEVEL_HIGH : mag[7:0];
    end else begin
      val = LEVEL_LOW;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      motion_value <= val;
      out_index    <= pix_q;
    end
  end

  // Status to the controller
  assign status.mod_done = DIRECT ? 1'b1 : mod_done_q;
  assign status.bypass   = (cfg.motion_threshold > 9'd255) ||
                           (cfg.binary_mode && (cfg.motion_threshold == 9'd0));
  assign status.out_busy = out_valid && !out_ready;
  assign status.clr_last = (clr_addr == LAST_A);

endmodule

>>> src/fmd_ctrl.sv
// ----------------------------------------------------------------------------
// fmd_ctrl
// Controller of the frame motion detector: sequences the clear sweep, the
// slot reduction, the blend and the output load for one item at a time.
// ----------------------------------------------------------------------------
module fmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  fmd_pkg::status_t  status,
  output fmd_pkg::cmd_t     cmd
);
  import fmd_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // State register: sweep the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = req_type ? ST_CLEAR : ST_MOD;
      end
      ST_MOD: begin
        if (status.mod_done) state_next = status.bypass ? ST_BYPASS : ST_READ;
      end
      ST_BYPASS: state_next = ST_OUT;
      ST_READ:   state_next = ST_MULA;
      ST_MULA:   state_next = ST_MULB;
      ST_MULB:   state_next = ST_BLEND;
      ST_BLEND:  state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_MULC;
      ST_MULC:   state_next = ST_OUT;
      ST_OUT: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_SAMPLE;
    cmd.wr_sel    = WR_BLEND;
    cmd.load_in   = accept;
    cmd.clr_start = accept && req_type;
    case (state)
      ST_CLEAR:  cmd.clr_write = 1'b1;
      ST_MOD:    cmd.mod_step  = !status.mod_done;
      ST_BYPASS: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SAMPLE;
      end
      ST_READ:   cmd.rd_en = 1'b1;
      ST_MULA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SAMPLE;
      end
      ST_MULB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_OLD;
        cmd.acc_en  = 1'b1;
      end
      ST_BLEND:  cmd.new_en = 1'b1;
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_BLEND;
      end
      ST_MULC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
      end
      ST_OUT:    cmd.load_out = !status.out_busy;
      default: ;
    endcase
  end

endmodule

>>> tb/fmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmd_checker
// Watches the APB port and both streaming channels of the frame motion
// detector. Keeps its own copy of the registers and of the running average
// store, predicts the motion result of every sample transfer and compares
// each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module fmd_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fmd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fmd_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [fmd_pkg::APB_DATA_W-1:0] prdata,
  input  logic                           pready,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           req_type,
  input  logic [7:0]                     sample,
  input  logic [15:0]                    pixel_index,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     motion_value,
  input  logic [15:0]                    out_index,
  output int                             fail_count,
  output int                             pending
);
  import fmd_pkg::*;

  localparam int unsigned STORE_DEPTH = 65536;

  typedef struct packed {
    logic [7:0]  motion;
    logic [15:0] index;
  } motion_rec_t;

  cfg_t        cfg;
  logic [15:0] running_avg [STORE_DEPTH];
  motion_rec_t expected_motion [$];

  // Zero every running average
  function automatic void wipe_averages();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      running_avg[i] = '0;
    end
  endfunction

  // Update the average of one position and work out its motion value
  function automatic motion_rec_t predict_motion(input logic [7:0] smp,
                                                 input logic [15:0] pix);
    logic [15:0] prev;
    logic [15:0] fresh;
    logic [15:0] delta;
    logic [63:0] acc;
    logic [31:0] scaled;
    logic [7:0]  hi;
    logic [7:0]  lo;
    motion_rec_t rec;
    hi = cfg.invert_mode ? LEVEL_LOW : LEVEL_HIGH;
    lo = cfg.invert_mode ? LEVEL_HIGH : LEVEL_LOW;
    rec.index = pix;
    if (cfg.motion_threshold > 9'(LEVEL_HIGH)) begin
      // nothing can pass: store the raw sample
      running_avg[pix] = {smp, 8'h00};
      rec.motion = cfg.binary_mode ? lo : LEVEL_LOW;
    end else if (cfg.binary_mode && cfg.motion_threshold == '0) begin
      // everything passes: store the raw sample
      running_avg[pix] = {smp, 8'h00};
      rec.motion = hi;
    end else begin
      prev = running_avg[pix];
      acc = (64'(smp) << 8) * (64'(ONE_Q16) - 64'(cfg.feedback_coeff))
          + 64'(prev) * 64'(cfg.feedback_coeff);
      acc = (acc + 64'(ROUND_HALF)) >> 16;
      fresh = (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
      running_avg[pix] = fresh;
      delta = (fresh >= prev) ? fresh - prev : prev - fresh;
      scaled = (32'(delta) * 32'(cfg.diff_gain)) >> 16;
      if (cfg.binary_mode) begin
        rec.motion = (scaled >= 32'(cfg.motion_threshold)) ? hi : lo;
      end else if (scaled >= 32'(cfg.motion_threshold)) begin
        rec.motion = (scaled > 32'(LEVEL_HIGH)) ? LEVEL_HIGH : scaled[7:0];
      end else begin
        rec.motion = LEVEL_LOW;
      end
    end
    return rec;
  endfunction

  always @(posedge clk) begin
    logic [APB_DATA_W-1:0] want;
    logic                  known;
    motion_rec_t           head;
    if (rst) begin
      cfg.feedback_coeff   = FEEDBACK_RESET;
      cfg.diff_gain        = GAIN_RESET;
      cfg.motion_threshold = THRESHOLD_RESET;
      cfg.binary_mode      = 1'b0;
      cfg.invert_mode      = 1'b0;
      wipe_averages();
      expected_motion.delete();
      fail_count = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_FEEDBACK:  cfg.feedback_coeff   = pwdata[15:0];
          REG_GAIN:      cfg.diff_gain        = pwdata[15:0];
          REG_THRESHOLD: cfg.motion_threshold = pwdata[8:0];
          REG_BINARY:    cfg.binary_mode      = pwdata[0];
          REG_INVERT:    cfg.invert_mode      = pwdata[0];
          default: ;
        endcase
      end

      // Check register reads
      if (psel && penable && !pwrite && pready) begin
        known = 1'b1;
        want  = '0;
        case (paddr[APB_ADDR_W-1:2])
          REG_FEEDBACK:  want = APB_DATA_W'(cfg.feedback_coeff);
          REG_GAIN:      want = APB_DATA_W'(cfg.diff_gain);
          REG_THRESHOLD: want = APB_DATA_W'(cfg.motion_threshold);
          REG_BINARY:    want = APB_DATA_W'(cfg.binary_mode);
          REG_INVERT:    want = APB_DATA_W'(cfg.invert_mode);
          default:       known = 1'b0;
        endcase
        if (known && prdata !== want) begin
          $error("prdata mismatch at paddr %0d: expected %0d, actual %0d",
                 paddr, want, prdata);
          fail_count++;
        end
      end

      // Compare each output transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_motion.size() == 0) begin
          $error("output transfer with no result pending: index %0d value %0d",
                 out_index, motion_value);
          fail_count++;
        end else begin
          head = expected_motion.pop_front();
          if (motion_value !== head.motion) begin
            $error("motion_value mismatch: expected %0d, actual %0d",
                   head.motion, motion_value);
            fail_count++;
          end
          if (out_index !== head.index) begin
            $error("out_index mismatch: expected %0d, actual %0d",
                   head.index, out_index);
            fail_count++;
          end
        end
      end

      // Predict from each input transfer
      if (in_valid && in_ready) begin
        if (req_type) begin
          wipe_averages();
        end else begin
          expected_motion.push_back(predict_motion(sample, pixel_index));
        end
      end
    end
    pending = expected_motion.size();
  end

endmodule

>>> tb/frame_motion_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_motion_detector_test
// Stimulus and verdict for the frame motion detector. Runs a directed pass
// over field extremes, both threshold bypass cases, unmapped registers and a
// store clear, then random phases with varied register settings and idle
// patterns on both channels. Checking is done by fmd_checker.
// ----------------------------------------------------------------------------
module frame_motion_detector_test;
  import fmd_pkg::*;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int CLEAR_AT    = 50;
  localparam int HOLD_AT     = 30;
  localparam int PAUSE_AT    = 60;
  localparam int HOLD_LEN    = 300;
  localparam int IDLE_GAP    = 20;
  localparam int END_GAP     = 100;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic                  req_type;
  logic [7:0]            sample;
  logic [15:0]           pixel_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            motion_value;
  logic [15:0]           out_index;

  int          fail_count;
  int          pending;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          rx_hold;
  logic [15:0] hot_base;
  logic [7:0]  drift;

  frame_motion_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sample       (sample),
    .pixel_index  (pixel_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .motion_value (motion_value),
    .out_index    (out_index)
  );

  fmd_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sample       (sample),
    .pixel_index  (pixel_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .motion_value (motion_value),
    .out_index    (out_index),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #15_000_000;
    $display("frame_motion_detector verification failed");
    $finish;
  end

  // Drive the receiver: random stalls, plus one long hold when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rx_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one input transfer; entered and left at a falling edge
  task automatic push_item(input logic rq, input logic [7:0] smp,
                           input logic [15:0] pix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    sample      <= smp;
    pixel_index <= pix;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Drain, then let a possible store sweep finish
  task automatic wait_idle();
    drain();
    repeat (IDLE_GAP) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-3:0] idx,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-3:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_all();
    apb_read(REG_FEEDBACK);
    apb_read(REG_GAIN);
    apb_read(REG_THRESHOLD);
    apb_read(REG_BINARY);
    apb_read(REG_INVERT);
  endtask

  task automatic set_config(input logic [15:0] fb, input logic [15:0] gain,
                            input logic [8:0] thr, input logic bin,
                            input logic inv);
    apb_write(REG_FEEDBACK, APB_DATA_W'(fb));
    apb_write(REG_GAIN, APB_DATA_W'(gain));
    apb_write(REG_THRESHOLD, APB_DATA_W'(thr));
    apb_write(REG_BINARY, APB_DATA_W'(bin));
    apb_write(REG_INVERT, APB_DATA_W'(inv));
    read_all();
  endtask

  // Register settings of each random phase, extremes included
  task automatic apply_phase_config(input int ph);
    logic [8:0] thr;
    case (ph)
      0: set_config(16'h8000, 16'd256, 9'd4, 1'b0, 1'b0);
      1: set_config(16'hFFFF, 16'hFFFF, 9'd1, 1'b1, 1'b1);
      2: set_config(16'h0000, 16'hFFFF, 9'd255, 1'b0, 1'b0);
      3: set_config(16'($urandom_range(65535)), 16'($urandom_range(4095)),
                    9'($urandom_range(32)), 1'b1, 1'b0);
      4: begin
        thr = ($urandom_range(7) == 0) ? 9'($urandom_range(511))
                                       : 9'($urandom_range(64));
        set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   thr, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      5: set_config(16'hC000, 16'd4096, 9'd0, 1'b0, 1'b1);
      default: set_config(16'($urandom_range(65535)), 16'd0,
                          9'($urandom_range(3)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
    endcase
  endtask

  // Mostly a small hot set of positions so averages evolve over many hits
  function automatic logic [15:0] pick_index();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return hot_base + 16'($urandom_range(15));
      6:                return hot_base ^ (16'd1 << $urandom_range(15));
      default:          return 16'($urandom_range(65535));
    endcase
  endfunction

  // Extremes, random jumps and slow drift
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(7))
      0:       drift = 8'd0;
      1:       drift = 8'hFF;
      2, 3:    drift = 8'($urandom_range(255));
      default: drift = drift + 8'($urandom_range(16)) - 8'd8;
    endcase
    return drift;
  endfunction

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    req_type    = REQ_SAMPLE;
    sample      = '0;
    pixel_index = '0;
    tx_idle_pct = 27;
    rx_idle_pct = 56;
    rx_hold     = 1'b0;
    hot_base    = '0;
    drift       = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // Reset settings: plain magnitude of the sample step
    read_all();
    push_item(REQ_SAMPLE, 8'd255, 16'd0);
    push_item(REQ_SAMPLE, 8'd255, 16'd0);
    push_item(REQ_SAMPLE, 8'd0, 16'd0);
    push_item(REQ_SAMPLE, 8'd0, 16'hFFFF);
    push_item(REQ_SAMPLE, 8'd255, 16'hFFFF);
    push_item(REQ_SAMPLE, 8'd128, 16'hAAAA);
    push_item(REQ_SAMPLE, 8'd127, 16'h5555);
    push_item(REQ_SAMPLE, 8'd1, 16'd1);

    // Threshold above the range: output low, raw sample stored
    wait_idle();
    set_config(16'h4000, 16'd256, 9'd256, 1'b0, 1'b0);
    push_item(REQ_SAMPLE, 8'd200, 16'hAAAA);
    push_item(REQ_SAMPLE, 8'd10, 16'hAAAA);
    wait_idle();
    set_config(16'h4000, 16'd256, 9'd511, 1'b1, 1'b1);
    push_item(REQ_SAMPLE, 8'd90, 16'h5555);
    push_item(REQ_SAMPLE, 8'd91, 16'h5555);

    // Binary mode with zero threshold: output high, raw sample stored
    wait_idle();
    set_config(16'h4000, 16'd256, 9'd0, 1'b1, 1'b0);
    push_item(REQ_SAMPLE, 8'd33, 16'd1);
    push_item(REQ_SAMPLE, 8'd34, 16'd1);
    wait_idle();
    apb_write(REG_INVERT, APB_DATA_W'(1'b1));
    apb_read(REG_INVERT);
    push_item(REQ_SAMPLE, 8'd35, 16'd1);
    push_item(REQ_SAMPLE, 8'd36, 16'd1);

    // Unmapped registers must leave the settings alone
    wait_idle();
    set_config(16'hFFFF, 16'hFFFF, 9'd1, 1'b0, 1'b0);
    for (int r = int'(REG_INVERT) + 1; r < (1 << (APB_ADDR_W - 2)); r++) begin
      apb_write(r[APB_ADDR_W-3:0], '1);
    end
    read_all();
    push_item(REQ_SAMPLE, 8'd255, 16'd3);
    push_item(REQ_SAMPLE, 8'd255, 16'd3);
    push_item(REQ_SAMPLE, 8'd0, 16'd3);
    // Clear request, then reuse a position that held an average
    push_item(REQ_CLEAR, 8'hA5, 16'h1234);
    push_item(REQ_SAMPLE, 8'd255, 16'd3);
    push_item(REQ_SAMPLE, 8'd255, 16'hFFFF);

    // Random phases
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      if (ph < 2) begin
        tx_idle_pct = 27;
        rx_idle_pct = 56;
      end else if (ph < 4) begin
        tx_idle_pct = 56;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apply_phase_config(ph);
      hot_base = 16'($urandom_range(65535));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == CLEAR_AT && ph % 2 == 1) begin
          push_item(REQ_CLEAR, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        end
        // long receiver hold while the sender keeps offering
        if (n == HOLD_AT && (ph == 0 || ph == 4)) begin
          rx_hold = 1'b1;
        end
        if (n == PAUSE_AT && ph == 2) begin
          drain();
        end
        push_item(REQ_SAMPLE, pick_sample(), pick_index());
      end
    end

    // Wait out the last results, then give the verdict
    drain();
    repeat (END_GAP) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("frame_motion_detector verification clean");
    end else begin
      $display("frame_motion_detector verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/fmd_pkg.sv
src/fmd_regs.sv
src/fmd_datapath.sv
src/fmd_ctrl.sv
src/frame_motion_detector.sv
tb/fmd_checker.sv
tb/frame_motion_detector_test.sv
